FILE: rtl/scac_pkg.sv
package scac_pkg;

    localparam int CMD_W      = 2;
    localparam int SLAB_IDX_W = 4;
    localparam int SLOT_IDX_W = 6;
    localparam int STATUS_W   = 2;
    localparam int FREED_W    = 20;
    localparam int ALLOC_W    = 11;
    localparam int SCNT_W     = 5;
    localparam int SPP_W      = 7;
    localparam int ORDER_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_SHRINK = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SLAB  = 2'd1,
        STAT_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        LST_EMPTY   = 2'd0,
        LST_PARTIAL = 2'd1,
        LST_FULL    = 2'd2
    } t_list;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOTS_PER_SLAB = 2'd0,
        REG_SLAB_ORDER     = 2'd1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_DESC,
        S_A_UPD,
        S_F_CHK,
        S_MV_P,
        S_MV_PW,
        S_MV_N,
        S_MV_NW,
        S_MV_T,
        S_MV_TW,
        S_DS_WR,
        S_SH_LOOP,
        S_SH_DESC,
        S_FIN
    } t_state;

endpackage

FILE: rtl/scac_if.sv
interface scac_in_if
    import scac_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      command;
    logic [SLAB_IDX_W-1:0] slab_index;
    logic [SLOT_IDX_W-1:0] slot_index;

    modport source (output valid, command, slab_index, slot_index, input ready);
    modport sink   (input valid, command, slab_index, slot_index, output ready);
endinterface

interface scac_out_if
    import scac_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLAB_IDX_W-1:0] got_slab;
    logic [SLOT_IDX_W-1:0] got_slot;
    logic [FREED_W-1:0]    freed_blocks;
    logic [ALLOC_W-1:0]    allocated_total;
    logic [SCNT_W-1:0]     slab_total;

    modport source (output valid, status, got_slab, got_slot, freed_blocks,
                    allocated_total, slab_total, input ready);
    modport sink   (input valid, status, got_slab, got_slot, freed_blocks,
                    allocated_total, slab_total, output ready);
endinterface

interface scac_cfg_if
    import scac_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/scac_ram.sv
module scac_ram #(
    parameter int             DEPTH     = 16,
    parameter int             DW        = 8,
    parameter bit             HAS_VALID = 1'b0,
    parameter logic [DW-1:0]  RST_VAL   = '0,
    localparam int            AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= mem[i_raddr];
        end
    end

    generate
        if (HAS_VALID) begin : g_valid
            // An entry never written since reset reads as the reset value.
            logic [DEPTH-1:0] r_vld;
            logic             r_qv;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld <= '0;
                    r_qv  <= 1'b0;
                end else begin
                    if (i_we) begin
                        r_vld[i_waddr] <= 1'b1;
                    end
                    if (i_re) begin
                        r_qv <= r_vld[i_raddr];
                    end
                end
            end

            assign o_rdata = r_qv ? r_q : RST_VAL;
        end else begin : g_plain
            assign o_rdata = r_q;
        end
    endgenerate

endmodule

FILE: rtl/slab_cache_allocator_core.sv
// One command is worked at a time: the input is ready only while idle, and a new command is
// accepted only after the previous one has loaded its result, which a stalled earlier result delays.
// Invalid frees, allocations with no descriptor left, repeated shrinks and unknown commands skip the
// list steps; shrink loops once per released slab. The time goes to the read-modify-write steps on
// the slab descriptor memory that relink the empty, partial and full lists.
// Reset is synchronous: control state, list heads and the per-entry valid bits of the
// descriptor and slot-taken memories clear on reset, with no clearing pass.
module slab_cache_allocator_core
    import scac_pkg::*;
#(
    parameter int MAX_SLABS = 16,
    parameter int MAX_SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scac_in_if.sink    i_in,
    scac_out_if.source o_out,
    scac_cfg_if.sink   i_cfg
);

    localparam int SBW  = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
    localparam int LW   = $clog2(MAX_SLABS + 1);
    localparam int SLW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int ACW  = $clog2(MAX_SLABS * MAX_SLOTS + 1);
    localparam int SCW  = $clog2(MAX_SLABS + 1);
    localparam int SPP_RST = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
    localparam logic [LW-1:0] NONE = LW'(MAX_SLABS);

    typedef struct packed {
        logic [SLW-1:0] qhead;
        logic [SLW-1:0] qtail;
        logic [CW-1:0]  fcnt;
        logic [CW-1:0]  init;   // untouched initial queue entries still ahead of head
        t_list          lstate;
        logic [LW-1:0]  nxt;
        logic [LW-1:0]  prv;
    } t_desc;

    localparam t_desc DESC_RST = '{qhead: '0, qtail: '0, fcnt: '0, init: '0,
                                   lstate: LST_EMPTY, nxt: NONE, prv: NONE};
    localparam int DW = $bits(t_desc);

    function automatic t_list norm_list(input t_list l);
        if (l == LST_PARTIAL || l == LST_FULL) begin
            return l;
        end
        return LST_EMPTY;
    endfunction

    function automatic logic [SLW-1:0] wrap_inc(input logic [SLW-1:0] v);
        if (v == SLW'(MAX_SLOTS - 1)) begin
            return '0;
        end
        return v + 1'b1;
    endfunction

    t_state               r_state, n_state;
    logic [SBW-1:0]       r_s, n_s;
    t_desc                r_ds, n_ds;
    t_list                r_from, n_from, r_to, n_to;
    logic                 r_rel, n_rel;
    logic [SLW-1:0]       r_sl, n_sl;
    t_status              r_status, n_status;
    logic [SBW-1:0]       r_gslab, n_gslab;
    logic [SLW-1:0]       r_gslot, n_gslot;
    logic [FREED_W-1:0]   r_freed, n_freed;
    logic [SCW-1:0]       r_nrel, n_nrel;
    logic [ACW-1:0]       r_alloc, n_alloc;
    logic [SCW-1:0]       r_scnt, n_scnt;
    logic                 r_grew, n_grew, r_shrunk, n_shrunk;
    logic [MAX_SLABS-1:0] r_inuse, n_inuse;
    logic [LW-1:0]        r_lhead [3];
    logic [LW-1:0]        n_lhead [3];
    logic [LW-1:0]        r_ltail [3];
    logic [LW-1:0]        n_ltail [3];
    logic [SPP_W-1:0]     r_spp, n_spp;
    logic [ORDER_W-1:0]   r_order, n_order;
    logic                 r_ov, n_ov;
    t_status              r_o_status;
    logic [SBW-1:0]       r_o_slab;
    logic [SLW-1:0]       r_o_slot;
    logic [FREED_W-1:0]   r_o_freed;
    logic [ACW-1:0]       r_o_alloc;
    logic [SCW-1:0]       r_o_scnt;
    logic                 out_load;

    logic                 d_we, d_re;
    logic [SBW-1:0]       d_wa, d_ra;
    t_desc                d_wd, d_rd;
    logic [DW-1:0]        d_rd_raw;
    logic                 q_we, q_re;
    logic [SBW+SLW-1:0]   q_wa, q_ra;
    logic [SLW-1:0]       q_wd, q_rd;
    logic                 w_we, w_re;
    logic [SBW-1:0]       w_wa, w_ra;
    logic [MAX_SLOTS-1:0] w_wd, w_rd;

    logic [SBW-1:0]       free_u;
    logic                 free_found;
    logic [1:0]           lidx;
    logic [CW-1:0]        spp_c;
    logic [SLW-1:0]       slot;
    logic [CW-1:0]        fc_new;
    logic [LW-1:0]        s_link;
    t_desc                tmp;
    logic [SPP_W-1:0]     cfg_v;

    scac_ram #(
        .DEPTH(2 ** SBW), .DW(DW), .HAS_VALID(1'b1), .RST_VAL(DESC_RST)
    ) u_desc (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_we(d_we), .i_waddr(d_wa), .i_wdata(d_wd),
        .i_re(d_re), .i_raddr(d_ra), .o_rdata(d_rd_raw)
    );
    assign d_rd = t_desc'(d_rd_raw);

    scac_ram #(
        .DEPTH(2 ** (SBW + SLW)), .DW(SLW), .HAS_VALID(1'b0), .RST_VAL('0)
    ) u_fq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_re(q_re), .i_raddr(q_ra), .o_rdata(q_rd)
    );

    scac_ram #(
        .DEPTH(2 ** SBW), .DW(MAX_SLOTS), .HAS_VALID(1'b1), .RST_VAL('0)
    ) u_taken (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_we(w_we), .i_waddr(w_wa), .i_wdata(w_wd),
        .i_re(w_re), .i_raddr(w_ra), .o_rdata(w_rd)
    );

    always_comb begin
        free_u     = '0;
        free_found = 1'b0;
        for (int i = MAX_SLABS - 1; i >= 0; i--) begin
            if (!r_inuse[i]) begin
                free_u     = SBW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign spp_c     = CW'(r_spp);
    assign s_link    = LW'(r_s);
    assign lidx      = (r_state == S_MV_T) ? r_to : r_from;
    assign out_load  = (r_state == S_FIN) && (!r_ov || o_out.ready);
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state  = r_state;
        n_s      = r_s;
        n_ds     = r_ds;
        n_from   = r_from;
        n_to     = r_to;
        n_rel    = r_rel;
        n_sl     = r_sl;
        n_status = r_status;
        n_gslab  = r_gslab;
        n_gslot  = r_gslot;
        n_freed  = r_freed;
        n_nrel   = r_nrel;
        n_alloc  = r_alloc;
        n_scnt   = r_scnt;
        n_grew   = r_grew;
        n_shrunk = r_shrunk;
        n_inuse  = r_inuse;
        n_lhead  = r_lhead;
        n_ltail  = r_ltail;
        n_spp    = r_spp;
        n_order  = r_order;
        n_ov     = r_ov && !o_out.ready;
        d_we = 1'b0; d_wa = '0; d_wd = DESC_RST; d_re = 1'b0; d_ra = '0;
        q_we = 1'b0; q_wa = '0; q_wd = '0;       q_re = 1'b0; q_ra = '0;
        w_we = 1'b0; w_wa = '0; w_wd = '0;       w_re = 1'b0; w_ra = '0;
        slot   = '0;
        fc_new = '0;
        tmp    = d_rd;
        cfg_v  = '0;

        if (i_cfg.valid) begin
            unique case (t_reg'(i_cfg.index))
                REG_SLOTS_PER_SLAB: begin
                    cfg_v = SPP_W'(i_cfg.data);
                    if (cfg_v == '0) begin
                        n_spp = SPP_W'(1);
                    end else if (32'(cfg_v) > MAX_SLOTS) begin
                        n_spp = SPP_W'(MAX_SLOTS);
                    end else begin
                        n_spp = cfg_v;
                    end
                end
                REG_SLAB_ORDER: n_order = ORDER_W'(i_cfg.data);
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_status = STAT_OK;
                    n_gslab  = '0;
                    n_gslot  = '0;
                    n_freed  = '0;
                    n_rel    = 1'b0;
                    unique case (t_cmd'(i_in.command))
                        CMD_ALLOC: begin
                            if (r_lhead[LST_PARTIAL] != NONE) begin
                                n_s     = SBW'(r_lhead[LST_PARTIAL]);
                                n_state = S_A_RD;
                            end else if (r_lhead[LST_EMPTY] != NONE) begin
                                n_s     = SBW'(r_lhead[LST_EMPTY]);
                                n_state = S_A_RD;
                            end else begin
                                n_grew = 1'b1;
                                if (free_found) begin
                                    // Both lists are empty, so the new slab is alone on
                                    // the empty list and needs no neighbor update.
                                    d_we = 1'b1;
                                    d_wa = free_u;
                                    d_wd = '{qhead: '0,
                                             qtail: (spp_c == CW'(MAX_SLOTS)) ? '0
                                                                             : SLW'(spp_c),
                                             fcnt: spp_c, init: spp_c, lstate: LST_EMPTY,
                                             nxt: NONE, prv: NONE};
                                    w_we = 1'b1;
                                    w_wa = free_u;
                                    w_wd = '0;
                                    n_lhead[LST_EMPTY] = LW'(free_u);
                                    n_ltail[LST_EMPTY] = LW'(free_u);
                                    n_inuse[free_u]    = 1'b1;
                                    n_scnt  = r_scnt + 1'b1;
                                    n_s     = free_u;
                                    n_state = S_A_RD;
                                end else begin
                                    n_status = STAT_NO_SLAB;
                                    n_state  = S_FIN;
                                end
                            end
                        end
                        CMD_FREE: begin
                            if (32'(i_in.slab_index) >= MAX_SLABS ||
                                32'(i_in.slot_index) >= MAX_SLOTS ||
                                !r_inuse[SBW'(i_in.slab_index)]) begin
                                n_status = STAT_BAD_FREE;
                                n_state  = S_FIN;
                            end else begin
                                n_s  = SBW'(i_in.slab_index);
                                n_sl = SLW'(i_in.slot_index);
                                d_re = 1'b1;
                                d_ra = SBW'(i_in.slab_index);
                                w_re = 1'b1;
                                w_ra = SBW'(i_in.slab_index);
                                n_state = S_F_CHK;
                            end
                        end
                        CMD_SHRINK: begin
                            if (r_shrunk && r_grew) begin
                                n_grew  = 1'b0;
                                n_state = S_FIN;
                            end else begin
                                n_shrunk = 1'b1;
                                n_grew   = 1'b0;
                                n_nrel   = '0;
                                n_state  = S_SH_LOOP;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_A_RD: begin
                d_re = 1'b1;
                d_ra = r_s;
                w_re = 1'b1;
                w_ra = r_s;
                n_state = S_A_DESC;
            end
            S_A_DESC: begin
                n_ds = d_rd;
                if (d_rd.fcnt == '0) begin
                    n_status = STAT_NO_SLAB;
                    n_state  = S_FIN;
                end else begin
                    q_re = 1'b1;
                    q_ra = {r_s, d_rd.qhead};
                    n_state = S_A_UPD;
                end
            end
            S_A_UPD: begin
                // Initial entries hold their own position and are never stored.
                slot   = (r_ds.init != '0) ? r_ds.qhead : q_rd;
                fc_new = r_ds.fcnt - 1'b1;
                w_we = 1'b1;
                w_wa = r_s;
                w_wd = w_rd | (MAX_SLOTS'(1) << slot);
                n_ds.qhead = wrap_inc(r_ds.qhead);
                n_ds.fcnt  = fc_new;
                if (r_ds.init != '0) begin
                    n_ds.init = r_ds.init - 1'b1;
                end
                n_alloc = r_alloc + 1'b1;
                n_gslab = r_s;
                n_gslot = slot;
                n_from  = norm_list(r_ds.lstate);
                if (fc_new == '0) begin
                    n_to    = LST_FULL;
                    n_state = S_MV_P;
                end else if ((CW + 1)'(fc_new) + 1'b1 == (CW + 1)'(spp_c)) begin
                    n_to    = LST_PARTIAL;
                    n_state = S_MV_P;
                end else begin
                    n_state = S_DS_WR;
                end
            end
            S_F_CHK: begin
                n_ds = d_rd;
                if (!w_rd[r_sl] || 32'(d_rd.fcnt) >= MAX_SLOTS) begin
                    n_status = STAT_BAD_FREE;
                    n_state  = S_FIN;
                end else begin
                    fc_new = d_rd.fcnt + 1'b1;
                    w_we = 1'b1;
                    w_wa = r_s;
                    w_wd = w_rd & ~(MAX_SLOTS'(1) << r_sl);
                    q_we = 1'b1;
                    q_wa = {r_s, d_rd.qtail};
                    q_wd = r_sl;
                    n_ds.qtail = wrap_inc(d_rd.qtail);
                    n_ds.fcnt  = fc_new;
                    if (r_alloc != '0) begin
                        n_alloc = r_alloc - 1'b1;
                    end
                    n_from = norm_list(d_rd.lstate);
                    if (fc_new >= spp_c) begin
                        n_to    = LST_EMPTY;
                        n_state = S_MV_P;
                    end else if (fc_new == CW'(1)) begin
                        n_to    = LST_PARTIAL;
                        n_state = S_MV_P;
                    end else begin
                        n_state = S_DS_WR;
                    end
                end
            end
            S_MV_P: begin
                if (r_ds.prv == NONE) begin
                    n_lhead[lidx] = r_ds.nxt;
                    n_state = S_MV_N;
                end else begin
                    d_re = 1'b1;
                    d_ra = SBW'(r_ds.prv);
                    n_state = S_MV_PW;
                end
            end
            S_MV_PW: begin
                tmp     = d_rd;
                tmp.nxt = r_ds.nxt;
                d_we = 1'b1;
                d_wa = SBW'(r_ds.prv);
                d_wd = tmp;
                n_state = S_MV_N;
            end
            S_MV_N: begin
                if (r_ds.nxt == NONE) begin
                    n_ltail[lidx] = r_ds.prv;
                    n_state = r_rel ? S_DS_WR : S_MV_T;
                end else begin
                    d_re = 1'b1;
                    d_ra = SBW'(r_ds.nxt);
                    n_state = S_MV_NW;
                end
            end
            S_MV_NW: begin
                tmp     = d_rd;
                tmp.prv = r_ds.prv;
                d_we = 1'b1;
                d_wa = SBW'(r_ds.nxt);
                d_wd = tmp;
                n_state = r_rel ? S_DS_WR : S_MV_T;
            end
            S_MV_T: begin
                n_ds.prv    = r_ltail[lidx];
                n_ds.nxt    = NONE;
                n_ds.lstate = r_to;
                n_ltail[lidx] = s_link;
                if (r_ltail[lidx] == NONE) begin
                    n_lhead[lidx] = s_link;
                    n_state = S_DS_WR;
                end else begin
                    d_re = 1'b1;
                    d_ra = SBW'(r_ltail[lidx]);
                    n_state = S_MV_TW;
                end
            end
            S_MV_TW: begin
                tmp     = d_rd;
                tmp.nxt = s_link;
                d_we = 1'b1;
                d_wa = SBW'(r_ds.prv);
                d_wd = tmp;
                n_state = S_DS_WR;
            end
            S_DS_WR: begin
                d_we = 1'b1;
                d_wa = r_s;
                if (r_rel) begin
                    tmp       = r_ds;
                    tmp.qhead = '0;
                    tmp.qtail = '0;
                    tmp.fcnt  = '0;
                    tmp.init  = '0;
                    tmp.nxt   = NONE;
                    tmp.prv   = NONE;
                    d_wd = tmp;
                    n_inuse[r_s] = 1'b0;
                    if (r_scnt != '0) begin
                        n_scnt = r_scnt - 1'b1;
                    end
                    n_nrel  = r_nrel + 1'b1;
                    n_state = S_SH_LOOP;
                end else begin
                    d_wd = r_ds;
                    n_state = S_FIN;
                end
            end
            S_SH_LOOP: begin
                if (r_lhead[LST_EMPTY] == NONE) begin
                    n_freed = FREED_W'(r_nrel) << r_order;
                    n_state = S_FIN;
                end else begin
                    n_s  = SBW'(r_lhead[LST_EMPTY]);
                    d_re = 1'b1;
                    d_ra = SBW'(r_lhead[LST_EMPTY]);
                    n_state = S_SH_DESC;
                end
            end
            S_SH_DESC: begin
                n_ds    = d_rd;
                n_from  = LST_EMPTY;
                n_rel   = 1'b1;
                n_state = S_MV_P;
            end
            S_FIN: begin
                if (out_load) begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rel    <= 1'b0;
            r_nrel   <= '0;
            r_alloc  <= '0;
            r_scnt   <= '0;
            r_grew   <= 1'b0;
            r_shrunk <= 1'b0;
            r_inuse  <= '0;
            r_lhead  <= '{default: NONE};
            r_ltail  <= '{default: NONE};
            r_spp    <= SPP_W'(SPP_RST);
            r_order  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rel    <= n_rel;
            r_nrel   <= n_nrel;
            r_alloc  <= n_alloc;
            r_scnt   <= n_scnt;
            r_grew   <= n_grew;
            r_shrunk <= n_shrunk;
            r_inuse  <= n_inuse;
            r_lhead  <= n_lhead;
            r_ltail  <= n_ltail;
            r_spp    <= n_spp;
            r_order  <= n_order;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s      <= n_s;
        r_ds     <= n_ds;
        r_from   <= n_from;
        r_to     <= n_to;
        r_sl     <= n_sl;
        r_status <= n_status;
        r_gslab  <= n_gslab;
        r_gslot  <= n_gslot;
        r_freed  <= n_freed;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_slab   <= r_gslab;
            r_o_slot   <= r_gslot;
            r_o_freed  <= r_freed;
            r_o_alloc  <= r_alloc;
            r_o_scnt   <= r_scnt;
        end
    end

    // The next command may start while a result waits, so the totals are captured with it.
    assign o_out.valid           = r_ov;
    assign o_out.status          = r_o_status;
    assign o_out.got_slab        = SLAB_IDX_W'(r_o_slab);
    assign o_out.got_slot        = SLOT_IDX_W'(r_o_slot);
    assign o_out.freed_blocks    = r_o_freed;
    assign o_out.allocated_total = ALLOC_W'(r_o_alloc);
    assign o_out.slab_total      = SCNT_W'(r_o_scnt);

`ifndef SYNTHESIS
    a_count_matches_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_inuse) == 32'(r_scnt))
        else $error("slab count disagrees with in-use descriptors");

    a_desc_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(d_we && d_re && d_wa == d_ra))
        else $error("descriptor read and write to the same entry in one cycle");

    a_alloc_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_alloc) <= MAX_SLABS * MAX_SLOTS)
        else $error("allocated slot count exceeds capacity");

    a_result_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_ov && r_state == S_IDLE))
        else $error("finished command did not present a result");
`endif

endmodule

FILE: dv/slab_cache_allocator_core_if_unused.sv
`timescale 1ns / 100ps

// Holders for one stimulus transfer on the command channel and one result transfer.
package scac_test_pkg;
    import scac_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [SLAB_IDX_W-1:0] slab_index;
        logic [SLOT_IDX_W-1:0] slot_index;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLAB_IDX_W-1:0] got_slab;
        logic [SLOT_IDX_W-1:0] got_slot;
        logic [FREED_W-1:0]    freed_blocks;
        logic [ALLOC_W-1:0]    allocated_total;
        logic [SCNT_W-1:0]     slab_total;
    } t_response;
endpackage

FILE: dv/slab_cache_allocator_core_test.sv
`timescale 1ns / 100ps

module slab_cache_allocator_core_test;
    import scac_pkg::*;
    import scac_test_pkg::*;

    localparam int NSLAB     = 16;
    localparam int NSLOT     = 64;
    localparam int NONE      = NSLAB;
    localparam int WDOG_MAX  = 20000;
    localparam int IDLE_WAIT = 200;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    scac_in_if  in_ch ();
    scac_out_if out_ch ();
    scac_cfg_if cfg_ch ();

    slab_cache_allocator_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Shadow of the allocator state.
    logic [5:0]  fq [NSLAB*NSLOT];
    logic [5:0]  q_head [NSLAB];
    logic [5:0]  q_tail [NSLAB];
    int          free_cnt [NSLAB];
    bit          taken [NSLAB*NSLOT];
    bit          in_use [NSLAB];
    t_list       on_list [NSLAB];
    int          nxt [NSLAB];
    int          prv [NSLAB];
    int          l_head [3];
    int          l_tail [3];
    int          alloc_cnt;
    int          slab_cnt;
    bit          grew;
    bit          shrunk;
    int          slots_cfg;
    int          order_cfg;

    t_request  pending_q [$];
    t_response expected_q [$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        wdog;
    int        err_cnt;
    bit        cfg_busy;
    bit        in_done;
    logic [CFG_IDX_W-1:0]  cfg_idx_next;
    logic [CFG_DATA_W-1:0] cfg_data_next;

    function automatic void shadow_reset();
        for (int i = 0; i < NSLAB * NSLOT; i++) begin
            fq[i] = '0;
            taken[i] = 1'b0;
        end
        for (int i = 0; i < NSLAB; i++) begin
            q_head[i] = '0;
            q_tail[i] = '0;
            free_cnt[i] = 0;
            in_use[i] = 1'b0;
            on_list[i] = LST_EMPTY;
            nxt[i] = NONE;
            prv[i] = NONE;
        end
        for (int i = 0; i < 3; i++) begin
            l_head[i] = NONE;
            l_tail[i] = NONE;
        end
        alloc_cnt = 0;
        slab_cnt = 0;
        grew = 1'b0;
        shrunk = 1'b0;
        slots_cfg = NSLOT;
        order_cfg = 0;
    endfunction

    function automatic void list_push(int l, int s);
        prv[s] = l_tail[l];
        nxt[s] = NONE;
        if (l_tail[l] == NONE) l_head[l] = s;
        else nxt[l_tail[l]] = s;
        l_tail[l] = s;
    endfunction

    function automatic void list_drop(int l, int s);
        int p;
        int n;
        p = prv[s];
        n = nxt[s];
        if (p == NONE) l_head[l] = n;
        else nxt[p] = n;
        if (n == NONE) l_tail[l] = p;
        else prv[n] = p;
        prv[s] = NONE;
        nxt[s] = NONE;
    endfunction

    function automatic void relist(int s, t_list to);
        list_drop(int'(on_list[s]), s);
        on_list[s] = to;
        list_push(int'(to), s);
    endfunction

    function automatic void apply_reg(t_reg idx, logic [CFG_DATA_W-1:0] v);
        if (idx == REG_SLOTS_PER_SLAB) begin
            slots_cfg = (v == 0) ? 1 : (v > NSLOT) ? NSLOT : int'(v);
        end else if (idx == REG_SLAB_ORDER) begin
            order_cfg = int'(v[3:0]);
        end
    endfunction

    function automatic t_response cache_step(t_request r);
        t_response o;
        int s;
        int n;
        logic [5:0] slot;
        o = '0;
        if (r.command == CMD_ALLOC) begin
            s = l_head[LST_PARTIAL];
            if (s == NONE) s = l_head[LST_EMPTY];
            if (s == NONE) begin
                // Grow from the lowest free descriptor, if any.
                for (n = 0; n < NSLAB; n++) if (!in_use[n]) break;
                if (n < NSLAB) begin
                    in_use[n] = 1'b1;
                    for (int i = 0; i < NSLOT; i++) begin
                        taken[n*NSLOT+i] = 1'b0;
                        if (i < slots_cfg) fq[n*NSLOT+i] = 6'(i);
                    end
                    q_head[n] = '0;
                    q_tail[n] = 6'(slots_cfg % NSLOT);
                    free_cnt[n] = slots_cfg;
                    on_list[n] = LST_EMPTY;
                    list_push(LST_EMPTY, n);
                    slab_cnt++;
                end
                grew = 1'b1;
                s = l_head[LST_EMPTY];
            end
            if (s == NONE || free_cnt[s] == 0) begin
                o.status = STAT_NO_SLAB;
            end else begin
                slot = fq[s*NSLOT+q_head[s]];
                q_head[s] = q_head[s] + 6'd1;
                free_cnt[s]--;
                taken[s*NSLOT+slot] = 1'b1;
                alloc_cnt++;
                if (free_cnt[s] == 0) relist(s, LST_FULL);
                else if (free_cnt[s] + 1 == slots_cfg) relist(s, LST_PARTIAL);
                o.got_slab = 4'(s);
                o.got_slot = slot;
            end
        end else if (r.command == CMD_FREE) begin
            s = int'(r.slab_index);
            if (!in_use[s] || !taken[s*NSLOT+r.slot_index] || free_cnt[s] >= NSLOT) begin
                o.status = STAT_BAD_FREE;
            end else begin
                taken[s*NSLOT+r.slot_index] = 1'b0;
                fq[s*NSLOT+q_tail[s]] = r.slot_index;
                q_tail[s] = q_tail[s] + 6'd1;
                free_cnt[s]++;
                if (alloc_cnt > 0) alloc_cnt--;
                if (free_cnt[s] >= slots_cfg) relist(s, LST_EMPTY);
                else if (free_cnt[s] == 1) relist(s, LST_PARTIAL);
            end
        end else if (r.command == CMD_SHRINK) begin
            if (shrunk && grew) begin
                grew = 1'b0;
            end else begin
                n = 0;
                shrunk = 1'b1;
                grew = 1'b0;
                while (l_head[LST_EMPTY] != NONE) begin
                    s = l_head[LST_EMPTY];
                    list_drop(LST_EMPTY, s);
                    in_use[s] = 1'b0;
                    free_cnt[s] = 0;
                    q_head[s] = '0;
                    q_tail[s] = '0;
                    if (slab_cnt > 0) slab_cnt--;
                    n++;
                end
                o.freed_blocks = FREED_W'(longint'(n) << order_cfg);
            end
        end
        o.allocated_total = ALLOC_W'(alloc_cnt);
        o.slab_total = SCNT_W'(slab_cnt);
        return o;
    endfunction

    // Picks a free that is usually legal: a slot currently held.
    function automatic t_request pick_free();
        t_request r;
        int tries;
        r.command = CMD_FREE;
        r.slab_index = 4'($urandom_range(0, NSLAB - 1));
        r.slot_index = 6'($urandom_range(0, NSLOT - 1));
        if ($urandom_range(0, 9) < 8 && alloc_cnt > 0) begin
            for (tries = 0; tries < 4000; tries++) begin
                if (taken[r.slab_index*NSLOT+r.slot_index] && in_use[r.slab_index]) break;
                r.slab_index = 4'($urandom_range(0, NSLAB - 1));
                r.slot_index = 6'($urandom_range(0, NSLOT - 1));
            end
        end
        return r;
    endfunction

    // Driver: command channel, result ready and configuration channel.
    // A command is replaced only after the rising edge that transferred it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_done) begin
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.command <= pending_q[0].command;
                in_ch.slab_index <= pending_q[0].slab_index;
                in_ch.slot_index <= pending_q[0].slot_index;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (cfg_busy && !cfg_ch.valid) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= cfg_idx_next;
            cfg_ch.data <= cfg_data_next;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            cfg_ch.valid <= 1'b0;
        end
    end

    // Monitor: predicts on each accepted command, checks each result transfer.
    always @(posedge i_clk) begin
        t_response got;
        t_response want;
        bit        act;
        in_done <= in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            act = (in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                  (out_ch.valid && out_ch.ready);
            wdog <= act ? 0 : wdog + 1;
            if (in_ch.valid && in_ch.ready) begin
                expected_q.push_back(cache_step(pending_q.pop_front()));
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_reg(t_reg'(cfg_ch.index), cfg_ch.data);
                cfg_busy <= 1'b0;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.status, out_ch.got_slab, out_ch.got_slot,
                        out_ch.freed_blocks, out_ch.allocated_total, out_ch.slab_total};
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    err_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        err_cnt++;
                    end
                    if (got.got_slab !== want.got_slab) begin
                        $error("got_slab exp %0d got %0d", want.got_slab, got.got_slab);
                        err_cnt++;
                    end
                    if (got.got_slot !== want.got_slot) begin
                        $error("got_slot exp %0d got %0d", want.got_slot, got.got_slot);
                        err_cnt++;
                    end
                    if (got.freed_blocks !== want.freed_blocks) begin
                        $error("freed_blocks exp %0d got %0d",
                               want.freed_blocks, got.freed_blocks);
                        err_cnt++;
                    end
                    if (got.allocated_total !== want.allocated_total) begin
                        $error("allocated_total exp %0d got %0d",
                               want.allocated_total, got.allocated_total);
                        err_cnt++;
                    end
                    if (got.slab_total !== want.slab_total) begin
                        $error("slab_total exp %0d got %0d", want.slab_total, got.slab_total);
                        err_cnt++;
                    end
                end
            end
            if (wdog >= WDOG_MAX) begin
                $display("slab_cache_allocator_core verification failed");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [CFG_DATA_W-1:0] v);
        @(posedge i_clk);
        cfg_idx_next = idx;
        cfg_data_next = v;
        cfg_busy = 1'b1;
        while (cfg_busy) @(posedge i_clk);
    endtask

    task automatic push_cmd(t_cmd c, int sb, int sl);
        t_request r;
        r.command = c;
        r.slab_index = 4'(sb);
        r.slot_index = 6'(sl);
        pending_q.push_back(r);
    endtask

    // Random burst: mostly allocate/free, sometimes shrink or the unused code.
    // Predictions are taken at acceptance, so each free is chosen after the queue drains.
    task automatic random_phase(int count);
        int k;
        t_request r;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            while (pending_q.size() > 0) @(posedge i_clk);
            if (k < 50) begin
                push_cmd(CMD_ALLOC, $urandom_range(0, 15), $urandom_range(0, 63));
            end else if (k < 92) begin
                pending_q.push_back(pick_free());
            end else if (k < 97) begin
                push_cmd(CMD_SHRINK, $urandom_range(0, 15), $urandom_range(0, 63));
            end else begin
                r.command = CMD_UNUSED;
                r.slab_index = 4'($urandom_range(0, 15));
                r.slot_index = 6'($urandom_range(0, 63));
                pending_q.push_back(r);
            end
        end
    endtask

    initial begin
        shadow_reset();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = '0;
        in_ch.slab_index = '0;
        in_ch.slot_index = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        cfg_busy = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wdog = 0;
        err_cnt = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: tiny slabs to hit full lists, descriptor exhaustion and bad frees.
        write_reg(REG_SLOTS_PER_SLAB, 7'd0);
        write_reg(REG_SLAB_ORDER, 4'd15);
        push_cmd(CMD_FREE, 0, 0);
        push_cmd(CMD_ALLOC, 0, 0);
        push_cmd(CMD_ALLOC, 0, 0);
        push_cmd(CMD_FREE, 0, 0);
        push_cmd(CMD_FREE, 0, 0);
        push_cmd(CMD_FREE, 15, 63);
        push_cmd(CMD_SHRINK, 0, 0);
        push_cmd(CMD_ALLOC, 0, 0);
        push_cmd(CMD_SHRINK, 0, 0);
        push_cmd(CMD_SHRINK, 0, 0);
        for (int i = 0; i < 14; i++) push_cmd(CMD_ALLOC, 0, 0);
        pending_q.push_back('{CMD_UNUSED, 4'hF, 6'h3F});
        drain();
        push_cmd(CMD_ALLOC, 0, 0);
        push_cmd(CMD_FREE, 0, 63);
        push_cmd(CMD_FREE, 3, 0);
        push_cmd(CMD_SHRINK, 0, 0);
        drain();

        write_reg(REG_SLOTS_PER_SLAB, 7'd127);
        write_reg(REG_SLAB_ORDER, 4'd0);
        send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(130);
        drain();
        write_reg(REG_SLOTS_PER_SLAB, 7'd5);
        write_reg(REG_SLAB_ORDER, 4'd3);
        send_idle_pct = 71; recv_stall_pct = 0;  random_phase(120);
        drain();
        write_reg(REG_SLOTS_PER_SLAB, 7'd64);
        write_reg(REG_SLAB_ORDER, 4'd15);
        send_idle_pct = 0;  recv_stall_pct = 71; random_phase(130);
        drain();
        write_reg(REG_SLOTS_PER_SLAB, 7'd1);
        write_reg(REG_SLAB_ORDER, 4'd7);
        send_idle_pct = 12; recv_stall_pct = 12; random_phase(120);
        drain();

        if (err_cnt == 0) begin
            $display("slab_cache_allocator_core verification clean");
        end else begin
            $display("slab_cache_allocator_core verification failed");
        end
        $finish;
    end
endmodule
